// ===== sv/rpn_stack_calculator_assert.svh =====
// Assertion macros for the RPN stack calculator checker
`ifndef RPN_STACK_CALCULATOR_ASSERT_SVH
`define RPN_STACK_CALCULATOR_ASSERT_SVH

// check outside reset
`define RPN_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// check at every edge, reset included
`define RPN_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/rpn_pkg.sv =====
// Types, codes and constants shared by the RPN stack calculator modules
package rpn_pkg;

   localparam int STACK_DEPTH_DEF = 16;
   localparam int DATA_W          = 32;
   localparam int DEPTH_W         = 5;
   localparam int DIV_STEPS       = 48;
   localparam int CNT_W           = $clog2(DIV_STEPS);

   localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh8000_0000;

   typedef enum logic [2:0] {
      KIND_PUSH = 3'd0,
      KIND_ADD  = 3'd1,
      KIND_SUB  = 3'd2,
      KIND_MUL  = 3'd3,
      KIND_DIV  = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      STAT_OK   = 3'd0,
      STAT_FEW  = 3'd1,
      STAT_FULL = 3'd2,
      STAT_DIVZ = 3'd3,
      STAT_SAT  = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_MUL,
      S_DIV,
      S_DIVEND,
      S_DONE
   } state_type;

   typedef struct packed {
      logic [2:0]               kind;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] top_value;
      logic [DEPTH_W-1:0]       depth;
      status_type               status;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic decode;
      logic exec;
      logic mul_end;
      logic div_step;
      logic div_end;
      logic respond;
   } cmd_type;

   typedef struct packed {
      logic oper_ok;
      logic addsub;
      logic mul;
      logic t_zero;
      logic div_last;
   } flags_type;

endpackage

// ===== sv/rpn_ram.sv =====
// Generic single-write, single-read RAM with registered read data
module rpn_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/rpn_ctrl.sv =====
// Controller state machine sequencing the RPN calculator datapath
module rpn_ctrl
   import rpn_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   output logic      req_ready,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   input  flags_type flags,
   output cmd_type   cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECODE;
         end
         S_DECODE: begin
            state_in = flags.oper_ok ? S_FETCH : S_DONE;
         end
         S_FETCH: begin
            if (flags.addsub) state_in = S_DONE;
            else if (flags.mul) state_in = S_MUL;
            else if (flags.t_zero) state_in = S_DONE;
            else state_in = S_DIV;
         end
         S_MUL: begin
            state_in = S_DONE;
         end
         S_DIV: begin
            if (flags.div_last) state_in = S_DIVEND;
         end
         S_DIVEND: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         S_DECODE: cmd.decode   = 1'b1;
         S_FETCH:  cmd.exec     = 1'b1;
         S_MUL:    cmd.mul_end  = 1'b1;
         S_DIV:    cmd.div_step = 1'b1;
         S_DIVEND: cmd.div_end  = 1'b1;
         S_DONE:   cmd.respond  = out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.respond) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/rpn_dpath.sv =====
// Datapath: stack pointer, top register, stack RAM, ALU, multiplier and divider
module rpn_dpath
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  req_type   req_payload,
   input  cmd_type   cmd,
   output flags_type flags,
   output rsp_type   rsp_payload
);

   localparam int DW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);
   localparam int QW = DATA_W + 16;

   logic [DW-1:0]            depth_ff, depth_in;
   logic [2:0]               kind_ff, kind_in;
   logic signed [DATA_W-1:0] value_ff, value_in;
   logic signed [DATA_W-1:0] top_ff, top_in;
   status_type               status_ff, status_in;
   logic signed [63:0]       prod_ff, prod_in;
   logic [DATA_W:0]          rem_ff, rem_in;
   logic [QW-1:0]            dvd_ff, dvd_in;
   logic [DATA_W-1:0]        den_ff, den_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic                     neg_ff, neg_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     wr_en, rd_en;
   logic [AW-1:0]            wr_addr, rd_addr;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] s_val;

   logic                     is_push, is_oper, full, few;
   logic [DATA_W:0]          add_sum, sub_dif, alu_sum;
   logic signed [DATA_W-1:0] alu_res;
   logic [QW-1:0]            psh;
   logic                     mul_sat;
   logic signed [DATA_W-1:0] mul_res;
   logic [DATA_W:0]          rem_sh, rem_sub;
   logic                     ge;
   logic [DATA_W-1:0]        s_abs, t_abs;
   logic                     div_sat;
   logic signed [DATA_W-1:0] div_res;
   logic signed [DATA_W-1:0] divz_res;

   assign s_val   = signed'(rd_data);
   assign is_push = (kind_ff == KIND_PUSH);
   assign is_oper = (kind_ff == KIND_ADD) || (kind_ff == KIND_SUB) ||
                    (kind_ff == KIND_MUL) || (kind_ff == KIND_DIV);
   assign full    = (depth_ff == DW'(STACK_DEPTH));
   assign few     = (depth_ff < DW'(2));

   assign wr_en   = cmd.decode && is_push && !full && (depth_ff != '0);
   assign wr_addr = AW'(depth_ff - DW'(1));
   assign rd_en   = cmd.decode && is_oper && !few;
   assign rd_addr = AW'(depth_ff - DW'(2));

   rpn_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (top_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign add_sum = {s_val[DATA_W-1], s_val} + {top_ff[DATA_W-1], top_ff};
   assign sub_dif = {s_val[DATA_W-1], s_val} - {top_ff[DATA_W-1], top_ff};
   assign alu_sum = (kind_ff == KIND_ADD) ? add_sum : sub_dif;
   assign alu_res = (alu_sum[DATA_W] != alu_sum[DATA_W-1]) ?
                    (alu_sum[DATA_W] ? Q_MIN : Q_MAX) : signed'(alu_sum[DATA_W-1:0]);

   assign psh     = prod_ff[63:16];
   assign mul_sat = !((&psh[QW-1:DATA_W-1]) || !(|psh[QW-1:DATA_W-1]));
   assign mul_res = mul_sat ? (psh[QW-1] ? Q_MIN : Q_MAX) : signed'(psh[DATA_W-1:0]);

   assign s_abs   = s_val[DATA_W-1] ? DATA_W'(-s_val) : DATA_W'(s_val);
   assign t_abs   = top_ff[DATA_W-1] ? DATA_W'(-top_ff) : DATA_W'(top_ff);
   assign rem_sh  = {rem_ff[DATA_W-1:0], dvd_ff[QW-1]};
   assign ge      = (rem_sh >= {1'b0, den_ff});
   assign rem_sub = rem_sh - {1'b0, den_ff};

   always_comb begin
      if (neg_ff) begin
         div_sat = (dvd_ff > QW'(64'h8000_0000));
         div_res = div_sat ? Q_MIN : signed'(DATA_W'(-dvd_ff[DATA_W-1:0]));
      end else begin
         div_sat = (dvd_ff > QW'(64'h7FFF_FFFF));
         div_res = div_sat ? Q_MAX : signed'(dvd_ff[DATA_W-1:0]);
      end
   end

   assign divz_res = s_val[DATA_W-1] ? Q_MIN : ((s_val == '0) ? '0 : Q_MAX);

   always_comb begin
      depth_in  = depth_ff;
      kind_in   = kind_ff;
      value_in  = value_ff;
      top_in    = top_ff;
      status_in = status_ff;
      prod_in   = prod_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      den_in    = den_ff;
      cnt_in    = cnt_ff;
      neg_in    = neg_ff;
      rsp_in    = rsp_ff;

      if (cmd.capture) begin
         kind_in  = req_payload.kind;
         value_in = req_payload.value;
      end

      if (cmd.decode) begin
         status_in = STAT_OK;
         if (is_push) begin
            if (full) begin
               status_in = STAT_FULL;
            end else begin
               top_in   = value_ff;
               depth_in = depth_ff + DW'(1);
            end
         end else if (is_oper && few) begin
            status_in = STAT_FEW;
         end
      end

      if (cmd.exec) begin
         if ((kind_ff == KIND_ADD) || (kind_ff == KIND_SUB)) begin
            top_in    = alu_res;
            depth_in  = depth_ff - DW'(1);
            status_in = (alu_sum[DATA_W] != alu_sum[DATA_W-1]) ? STAT_SAT : STAT_OK;
         end else if (kind_ff == KIND_MUL) begin
            prod_in = 64'(s_val) * 64'(top_ff);
         end else if (top_ff == '0) begin
            top_in    = divz_res;
            depth_in  = depth_ff - DW'(1);
            status_in = STAT_DIVZ;
         end else begin
            dvd_in = {s_abs, 16'h0000};
            den_in = t_abs;
            rem_in = '0;
            cnt_in = '0;
            neg_in = s_val[DATA_W-1] ^ top_ff[DATA_W-1];
         end
      end

      if (cmd.mul_end) begin
         top_in    = mul_res;
         depth_in  = depth_ff - DW'(1);
         status_in = mul_sat ? STAT_SAT : STAT_OK;
      end

      if (cmd.div_step) begin
         rem_in = ge ? rem_sub : rem_sh;
         dvd_in = {dvd_ff[QW-2:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
      end

      if (cmd.div_end) begin
         top_in    = div_res;
         depth_in  = depth_ff - DW'(1);
         status_in = div_sat ? STAT_SAT : STAT_OK;
      end

      if (cmd.respond) begin
         rsp_in.top_value = (depth_ff != '0) ? top_ff : '0;
         rsp_in.depth     = DEPTH_W'(depth_ff);
         rsp_in.status    = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      value_ff  <= value_in;
      top_ff    <= top_in;
      status_ff <= status_in;
      prod_ff   <= prod_in;
      rem_ff    <= rem_in;
      dvd_ff    <= dvd_in;
      den_ff    <= den_in;
      cnt_ff    <= cnt_in;
      neg_ff    <= neg_in;
      rsp_ff    <= rsp_in;
   end

   assign flags.oper_ok  = is_oper && !few;
   assign flags.addsub   = (kind_ff == KIND_ADD) || (kind_ff == KIND_SUB);
   assign flags.mul      = (kind_ff == KIND_MUL);
   assign flags.t_zero   = (top_ff == '0);
   assign flags.div_last = (cnt_ff == CNT_W'(DIV_STEPS - 1));

   assign rsp_payload = rsp_ff;

endmodule

// ===== sv/rpn_stack_calculator.sv =====
// Top level of the RPN stack calculator: controller plus datapath
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_type  (kind, value)
//   rsp      out        rsp_valid/rsp_ready    rsp_type  (top_value, depth, status)
//
// Push, error and unknown kinds go from decode straight to done; add/subtract and
// divide by zero finish in the fetch state, multiply in the multiply state, and divide
// in the radix-2 restoring divider, one quotient bit per cycle over 48 bits. Top of
// stack lives in a register, the rest in a RAM with one write and one registered read port.
// Reset clears depth, state and rsp_valid; no clearing pass over the RAM.
// A result waiting in the output register does not block the next transfer in;
// the following result waits until that register is taken.
module rpn_stack_calculator
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type   cmd;
   flags_type flags;

   rpn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .flags     (flags),
      .cmd       (cmd)
   );

   rpn_dpath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .flags       (flags),
      .rsp_payload (rsp_payload)
   );

endmodule

// ===== sv/rpn_checker.sv =====
// Port-level checker for the RPN stack calculator, bound to the top level
`include "rpn_stack_calculator_assert.svh"

module rpn_checker
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_payload
);

   `RPN_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_valid, "rsp_valid after reset")
   `RPN_ASSERT(a_busy_after_transfer, (req_valid && req_ready) |=> !req_ready, "ready while busy")
   `RPN_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_payload)), "rsp dropped or changed while stalled")
   `RPN_ASSERT(a_few_depth, (rsp_valid && (rsp_payload.status == STAT_FEW)) |-> (rsp_payload.depth <= DEPTH_W'(1)), "too-few status with deep stack")
   `RPN_ASSERT(a_full_depth, (rsp_valid && (rsp_payload.status == STAT_FULL)) |-> (rsp_payload.depth == DEPTH_W'(STACK_DEPTH)), "full status below capacity")

endmodule

bind rpn_stack_calculator rpn_checker #(
   .STACK_DEPTH (STACK_DEPTH)
) u_rpn_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ===== tb/rpn_stack_checker.sv =====
// Checker for the RPN stack calculator: watches both channels, predicts results and compares them
module rpn_stack_checker
   import rpn_pkg::*;
#(
   parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_ready,
   input  req_type    req_payload,
   input  logic       rsp_valid,
   input  logic       rsp_ready,
   input  rsp_type    rsp_payload,
   output int         mismatches,
   output int         outstanding,
   output int         results_checked,
   output logic [4:0] statuses_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   logic signed [DATA_W-1:0] stack_vals [STACK_DEPTH];
   int                       stack_count;
   rsp_type                  pending_results [$];

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   function automatic rsp_type evaluate_rpn(input req_type item);
      rsp_type                  outcome;
      status_type               st;
      logic signed [63:0]       s, t, wide, hi, lo;
      logic signed [DATA_W-1:0] res;
      st = STAT_OK;
      hi = Q_MAX;
      lo = Q_MIN;
      case (item.kind)
         KIND_PUSH: begin
            if (stack_count >= STACK_DEPTH) begin
               st = STAT_FULL;
            end else begin
               stack_vals[stack_count] = item.value;
               stack_count++;
            end
         end
         KIND_ADD, KIND_SUB, KIND_MUL, KIND_DIV: begin
            if (stack_count < 2) begin
               st = STAT_FEW;
            end else begin
               t = stack_vals[stack_count-1];
               s = stack_vals[stack_count-2];
               case (item.kind)
                  KIND_ADD: wide = s + t;
                  KIND_SUB: wide = s - t;
                  KIND_MUL: wide = (s * t) >>> 16;
                  default: begin
                     if (t == 0) begin
                        st = STAT_DIVZ;
                        wide = (s > 0) ? hi : ((s < 0) ? lo : 64'sd0);
                     end else begin
                        wide = (s * 64'sd65536) / t;
                     end
                  end
               endcase
               if (wide > hi) begin
                  res = Q_MAX;
                  st = STAT_SAT;
               end else if (wide < lo) begin
                  res = Q_MIN;
                  st = STAT_SAT;
               end else begin
                  res = wide[DATA_W-1:0];
               end
               stack_count--;
               stack_vals[stack_count-1] = res;
            end
         end
         default: ;
      endcase
      outcome.top_value = (stack_count > 0) ? stack_vals[stack_count-1] : '0;
      outcome.depth     = DEPTH_W'(stack_count);
      outcome.status    = st;
      return outcome;
   endfunction

   always @(posedge clock) begin
      rsp_type due;
      if (reset) begin
         stack_count = 0;
         pending_results.delete();
         mismatches = 0;
         results_checked = 0;
         statuses_seen = '0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: top %h depth %0d status %0d",
                  rsp_payload.top_value, rsp_payload.depth, rsp_payload.status));
            end else begin
               due = pending_results.pop_front();
               if (rsp_payload.top_value !== due.top_value)
                  report_mismatch($sformatf("top_value %h, predicted %h",
                     rsp_payload.top_value, due.top_value));
               if (rsp_payload.depth !== due.depth)
                  report_mismatch($sformatf("depth %0d, predicted %0d",
                     rsp_payload.depth, due.depth));
               if (rsp_payload.status !== due.status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                     rsp_payload.status, due.status));
               results_checked++;
               statuses_seen[rsp_payload.status] = 1'b1;
            end
         end
         if (req_valid && req_ready)
            pending_results.push_back(evaluate_rpn(req_payload));
      end
      outstanding <= pending_results.size();
   end

endmodule

// ===== tb/tb_rpn_stack_calculator.sv =====
// Testbench top for the RPN stack calculator: clock, reset, stimulus, flow control and verdict
module tb_rpn_stack_calculator;
   timeunit 1ns;
   timeprecision 1ps;
   import rpn_pkg::*;

   localparam logic [2:0] KIND_SPARE_FIRST = 3'd5;
   localparam logic [2:0] KIND_SPARE_LAST  = 3'd7;
   localparam int         RANDOM_OPS       = 950;

   typedef enum int {SEQ_CLIMB, SEQ_FALL, SEQ_BALANCED} seq_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;

   int         mismatches;
   int         outstanding;
   int         results_checked;
   logic [4:0] statuses_seen;

   int         shadow_depth;
   int         ops_sent;
   int         spare_sent;
   int         ready_mode;
   int         mode_left;
   int         stall_left;

   rpn_stack_calculator #(.STACK_DEPTH(STACK_DEPTH_DEF)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   rpn_stack_checker #(.STACK_DEPTH(STACK_DEPTH_DEF)) scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .results_checked (results_checked),
      .statuses_seen   (statuses_seen)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("simulation failed");
      $finish;
   end

   always @(negedge clock) begin
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 300);
      end
      mode_left--;
      case (ready_mode)
         0: rsp_ready = 1'b1;
         1: rsp_ready = ($urandom_range(0, 3) != 0);
         default: begin
            if (stall_left > 0) begin
               stall_left--;
               rsp_ready = 1'b0;
            end else if ($urandom_range(0, 5) == 0) begin
               stall_left = $urandom_range(1, 20);
               rsp_ready = 1'b0;
            end else begin
               rsp_ready = 1'b1;
            end
         end
      endcase
   end

   task automatic send(input logic [2:0] kind, input logic signed [DATA_W-1:0] value);
      @(negedge clock);
      req_valid = 1'b1;
      req_payload.kind  = kind;
      req_payload.value = value;
      do @(posedge clock); while (!req_ready);
      if (kind == KIND_PUSH) begin
         if (shadow_depth < STACK_DEPTH_DEF)
            shadow_depth++;
      end else if (kind <= KIND_DIV && shadow_depth >= 2) begin
         shadow_depth--;
      end
      if (kind <= KIND_DIV)
         ops_sent++;
      else
         spare_sent++;
   endtask

   task automatic pause_sender(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid = 1'b0;
         req_payload.kind  = 3'($urandom);
         req_payload.value = $urandom;
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (outstanding != 0)
         @(negedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3: return ($urandom_range(0, 1) != 0) ? 32'sh0001_0000 : -32'sh0001_0000;
         4, 5: return $urandom;
         default: return 32'($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
      endcase
   endfunction

   initial begin
      seq_mode_type seq_mode;
      int           seq_left;
      int           burst_left;
      int           push_pct;
      logic [2:0]   kind;

      seq_left   = 0;
      burst_left = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send(KIND_ADD, '0);
      send(KIND_PUSH, Q_MAX);
      send(KIND_SUB, '0);
      send(KIND_PUSH, Q_MAX);
      send(KIND_ADD, '0);
      send(KIND_PUSH, Q_MIN);
      send(KIND_SUB, '0);
      send(KIND_PUSH, '0);
      send(KIND_DIV, '0);
      send(KIND_PUSH, -32'sd1);
      send(KIND_MUL, '0);
      send(KIND_PUSH, Q_MIN);
      send(KIND_PUSH, '0);
      send(KIND_DIV, '0);
      send(KIND_PUSH, '0);
      send(KIND_PUSH, '0);
      send(KIND_DIV, '0);
      send(KIND_PUSH, Q_MIN);
      send(KIND_PUSH, -32'sh0001_0000);
      send(KIND_DIV, '0);
      send(KIND_PUSH, Q_MIN);
      send(KIND_MUL, '0);
      send(KIND_SPARE_FIRST, Q_MAX);
      send(KIND_SPARE_LAST, '0);
      send(KIND_PUSH, -32'sh0003_8000);
      send(KIND_DIV, '0);
      drain_results();

      ops_sent = 0;
      while (ops_sent < RANDOM_OPS) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 9) < 3)
               pause_sender(0);
            else
               pause_sender($urandom_range(1, 10));
            burst_left = $urandom_range(1, 16);
         end
         burst_left--;
         if (seq_left == 0) begin
            seq_mode = seq_mode_type'($urandom_range(SEQ_CLIMB, SEQ_BALANCED));
            seq_left = $urandom_range(20, 60);
         end
         seq_left--;
         case (seq_mode)
            SEQ_CLIMB: push_pct = 80;
            SEQ_FALL:  push_pct = 25;
            default:   push_pct = 50;
         endcase
         if (shadow_depth < 2)
            push_pct = 90;
         if ($urandom_range(0, 99) < 3)
            kind = 3'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
         else if ($urandom_range(0, 99) < push_pct)
            kind = KIND_PUSH;
         else
            kind = 3'($urandom_range(KIND_ADD, KIND_DIV));
         send(kind, pick_value());
         if (ops_sent % 300 == 299)
            drain_results();
      end

      drain_results();
      repeat (60) @(posedge clock);
      $display("%0d operations and %0d undefined kinds sent, %0d results checked",
         ops_sent, spare_sent, results_checked);
      $display("status codes returned (saturated, div-zero, full, few, ok): %b", statuses_seen);
      if (mismatches == 0 && outstanding == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rpn_pkg.sv
sv/rpn_ram.sv
sv/rpn_ctrl.sv
sv/rpn_dpath.sv
sv/rpn_stack_calculator.sv
sv/rpn_checker.sv
tb/rpn_stack_checker.sv
tb/tb_rpn_stack_calculator.sv
